// ===== rtl/msjd_pkg.sv =====
`default_nettype none

package msjd_pkg;

   localparam int TIME_W   = 32;
   localparam int SVC_W    = 16;
   localparam int TAG_W    = 16;
   localparam int SRV_NUM_W = 3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_SELECT,
      S_UPDATE,
      S_RESP
   } msjd_state_type;

   // per-entry verdict of the shared compare unit
   typedef struct packed {
      logic take_free;   // first free server seen, scanning downward
      logic take_min;    // new earliest busy-until (ties keep higher number)
   } cmp_result_type;

   // a + b, saturating at the top of the 32-bit range
   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [SVC_W-1:0]  b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {{(TIME_W+1-SVC_W){1'b0}}, b};
      return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/multi_server_job_dispatcher_unit.sv =====
`default_nettype none

// Channel | Dir | Handshake          | Beat contents
// req     | in  | req_valid/ready    | job_id, arrival_time, service_time
// rsp     | out | rsp_valid/ready    | job_tag, server_number, begin/finish, wait, busy sum
//
// The scan walks the busy-until memory one entry per cycle through the single
//   compare unit, then drain, select, update and respond.
// One beat in flight at a time; req_ready is high only while idle, so accepts
//   are made only after the previous result beat has been taken.
// Reset (synchronous) clears the sequencer and the memory valid bits, so
//   every server reads as free with a zero total right away.
// A stalled rsp beat holds in its output registers until taken.
module multi_server_job_dispatcher_unit #(
   parameter int SERVER_COUNT = 6
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [msjd_pkg::TAG_W-1:0]        req_job_id,
   input  wire logic [msjd_pkg::TIME_W-1:0]       req_arrival_time,
   input  wire logic [msjd_pkg::SVC_W-1:0]        req_service_time,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [msjd_pkg::TAG_W-1:0]        rsp_job_tag,
   output logic      [msjd_pkg::SRV_NUM_W-1:0]    rsp_server_number,
   output logic      [msjd_pkg::TIME_W-1:0]       rsp_begin_time,
   output logic      [msjd_pkg::TIME_W-1:0]       rsp_finish_time,
   output logic      [msjd_pkg::TIME_W-1:0]       rsp_wait_ticks,
   output logic      [msjd_pkg::TIME_W-1:0]       rsp_server_busy_sum
);

   localparam int IDX_W = (SERVER_COUNT > 1) ? $clog2(SERVER_COUNT) : 1;
   localparam int NUM_W = (IDX_W + 1 > msjd_pkg::SRV_NUM_W) ? IDX_W + 1
                                                            : msjd_pkg::SRV_NUM_W;
   localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(SERVER_COUNT - 1);

   msjd_pkg::msjd_state_type state_ff, state_in;

   // job beat
   logic [msjd_pkg::TAG_W-1:0]  tag_ff;
   logic [msjd_pkg::TIME_W-1:0] arr_ff;
   logic [msjd_pkg::SVC_W-1:0]  svc_ff;

   // scan
   logic [IDX_W-1:0]            idx_ff;
   logic                        cmp_vld_ff;
   logic [IDX_W-1:0]            cmp_idx_ff;
   logic                        found_ff;
   logic [IDX_W-1:0]            free_idx_ff;
   logic [msjd_pkg::TIME_W-1:0] best_ff;
   logic [IDX_W-1:0]            min_idx_ff;

   // selection / result
   logic [IDX_W-1:0]            chosen_ff;
   logic [IDX_W-1:0]            chosen_in;
   logic [msjd_pkg::TIME_W-1:0] begin_ff;
   logic [msjd_pkg::TIME_W-1:0] fin_ff;
   logic [msjd_pkg::TIME_W-1:0] wait_ff;
   logic [msjd_pkg::TIME_W-1:0] sum_ff;
   logic [NUM_W-1:0]            num_ff;

   // control
   logic                        req_acc;
   logic                        do_select;
   logic                        do_update;
   logic [IDX_W-1:0]            rd_addr;
   logic [msjd_pkg::TIME_W-1:0] rd_until;
   logic [msjd_pkg::TIME_W-1:0] rd_sum;
   logic [msjd_pkg::TIME_W-1:0] fin_in;
   logic [msjd_pkg::TIME_W-1:0] sum_in;
   msjd_pkg::cmp_result_type    cmp_res;

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msjd_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         msjd_pkg::S_IDLE:   if (req_valid) state_in = msjd_pkg::S_SCAN;
         msjd_pkg::S_SCAN:   if (idx_ff == '0) state_in = msjd_pkg::S_DRAIN;
         msjd_pkg::S_DRAIN:  state_in = msjd_pkg::S_SELECT;
         msjd_pkg::S_SELECT: state_in = msjd_pkg::S_UPDATE;
         msjd_pkg::S_UPDATE: state_in = msjd_pkg::S_RESP;
         msjd_pkg::S_RESP:   if (rsp_ready) state_in = msjd_pkg::S_IDLE;
         default:            state_in = msjd_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      do_select = 1'b0;
      do_update = 1'b0;
      case (state_ff)
         msjd_pkg::S_IDLE:   req_ready = 1'b1;
         msjd_pkg::S_SELECT: do_select = 1'b1;
         msjd_pkg::S_UPDATE: do_update = 1'b1;
         msjd_pkg::S_RESP:   rsp_valid = 1'b1;
         default: begin
         end
      endcase
   end

   assign req_acc = req_valid && req_ready;

   // winner: first free server from the top, else earliest release
   assign chosen_in = found_ff ? free_idx_ff : min_idx_ff;
   // scan walks idx downward; select re-reads the winner for its total
   assign rd_addr   = do_select ? chosen_in : idx_ff;

   // ---------------- storage and compare ----------------
   msjd_store #(
      .DEPTH (SERVER_COUNT)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .wr_en    (do_update),
      .wr_addr  (chosen_ff),
      .wr_until (fin_in),
      .wr_sum   (sum_in),
      .rd_until (rd_until),
      .rd_sum   (rd_sum)
   );

   msjd_cmp u_cmp (
      .entry_until (rd_until),
      .arrival     (arr_ff),
      .best        (best_ff),
      .found       (found_ff),
      .first       (cmp_idx_ff == TOP_IDX),
      .result      (cmp_res)
   );

   assign fin_in = msjd_pkg::sat_add(begin_ff, svc_ff);
   assign sum_in = msjd_pkg::sat_add(rd_sum, svc_ff);

   // read data arrives in the cycle after its address (registered read port)
   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= (state_ff == msjd_pkg::S_SCAN);
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= idx_ff;
      if (req_acc) begin
         tag_ff   <= req_job_id;
         arr_ff   <= req_arrival_time;
         svc_ff   <= req_service_time;
         idx_ff   <= TOP_IDX;
         found_ff <= 1'b0;
      end else if (state_ff == msjd_pkg::S_SCAN && idx_ff != '0) begin
         idx_ff <= idx_ff - IDX_W'(1);
      end
      if (cmp_vld_ff) begin
         if (cmp_res.take_free) begin
            found_ff    <= 1'b1;
            free_idx_ff <= cmp_idx_ff;
         end
         if (cmp_res.take_min) begin
            best_ff    <= rd_until;
            min_idx_ff <= cmp_idx_ff;
         end
      end
      if (do_select) begin
         chosen_ff <= chosen_in;
         begin_ff  <= found_ff ? arr_ff : best_ff;
      end
      if (do_update) begin
         fin_ff  <= fin_in;
         sum_ff  <= sum_in;
         wait_ff <= begin_ff - arr_ff;
         num_ff  <= NUM_W'(chosen_ff) + NUM_W'(1);
      end
   end

   assign rsp_job_tag         = tag_ff;
   assign rsp_server_number   = num_ff[msjd_pkg::SRV_NUM_W-1:0];
   assign rsp_begin_time      = begin_ff;
   assign rsp_finish_time     = fin_ff;
   assign rsp_wait_ticks      = wait_ff;
   assign rsp_server_busy_sum = sum_ff;

   // ---------------- checks ----------------
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready)
      else $error("req_ready high right after accepting a beat");

   a_start_not_early: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (begin_ff >= arr_ff))
      else $error("service begins before arrival");

   a_finish_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_finish_time >= rsp_begin_time))
      else $error("finish time earlier than begin time");

   a_chosen_in_range: assert property (@(posedge clock) disable iff (reset)
      do_update |-> (32'(chosen_ff) < 32'(SERVER_COUNT)))
      else $error("selected server index out of range");

   a_scan_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == msjd_pkg::S_DRAIN) |-> cmp_vld_ff && (cmp_idx_ff == '0))
      else $error("scan did not end on the lowest server");

endmodule

`default_nettype wire

// ===== rtl/msjd_store.sv =====
`default_nettype none

// Per-server busy-until and busy-total memories. One registered read port,
// one write port. Entries never written read as zero.
module msjd_store #(
   parameter int DEPTH = 6
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   input  wire logic                                  wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [msjd_pkg::TIME_W-1:0]           wr_until,
   input  wire logic [msjd_pkg::TIME_W-1:0]           wr_sum,
   output logic      [msjd_pkg::TIME_W-1:0]           rd_until,
   output logic      [msjd_pkg::TIME_W-1:0]           rd_sum
);

   logic [DEPTH-1:0]                vld_ff;
   logic [msjd_pkg::TIME_W-1:0]     until_mem_ff [DEPTH];
   logic [msjd_pkg::TIME_W-1:0]     sum_mem_ff   [DEPTH];
   logic [msjd_pkg::TIME_W-1:0]     rd_until_ff;
   logic [msjd_pkg::TIME_W-1:0]     rd_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         until_mem_ff[wr_addr] <= wr_until;
         sum_mem_ff[wr_addr]   <= wr_sum;
      end
   end

   always_ff @(posedge clock) begin
      rd_until_ff <= vld_ff[rd_addr] ? until_mem_ff[rd_addr] : '0;
      rd_sum_ff   <= vld_ff[rd_addr] ? sum_mem_ff[rd_addr]   : '0;
   end

   assign rd_until = rd_until_ff;
   assign rd_sum   = rd_sum_ff;

endmodule

`default_nettype wire

// ===== rtl/msjd_cmp.sv =====
`default_nettype none

// Shared compare unit, one server entry per use.
module msjd_cmp (
   input  wire logic [msjd_pkg::TIME_W-1:0] entry_until,
   input  wire logic [msjd_pkg::TIME_W-1:0] arrival,
   input  wire logic [msjd_pkg::TIME_W-1:0] best,
   input  wire logic                        found,
   input  wire logic                        first,
   output msjd_pkg::cmp_result_type         result
);

   always_comb begin
      result.take_free = !found && (entry_until <= arrival);
      result.take_min  = first || (entry_until < best);
   end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

// Job dispatcher bench: jobs go in one beat at a time, each produces exactly one
// assignment beat. A behavioral copy of the server table predicts every beat.
module tb;

   localparam int TIME_W    = msjd_pkg::TIME_W;
   localparam int SVC_W     = msjd_pkg::SVC_W;
   localparam int TAG_W     = msjd_pkg::TAG_W;
   localparam int SRV_NUM_W = msjd_pkg::SRV_NUM_W;

   localparam int SERVER_COUNT = 6;
   // Limit is 8x a generous bound on the slowest legal run (about 1850 jobs,
   // random gaps on both sides, one HOLD_CYCLES output hold).
   localparam int unsigned CYCLE_LIMIT = 400_000;
   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_PCT = 16;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   // one predicted or observed assignment beat
   typedef struct packed {
      logic [TAG_W-1:0]     tag;
      logic [SRV_NUM_W-1:0] server;
      logic [TIME_W-1:0]    start_tick;
      logic [TIME_W-1:0]    end_tick;
      logic [TIME_W-1:0]    wait_ticks;
      logic [TIME_W-1:0]    busy_total;
   } dispatch_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [TAG_W-1:0]  req_job_id = '0;
   logic [TIME_W-1:0] req_arrival_time = '0;
   logic [SVC_W-1:0]  req_service_time = '0;

   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [TAG_W-1:0]     rsp_job_tag;
   logic [SRV_NUM_W-1:0] rsp_server_number;
   logic [TIME_W-1:0]    rsp_begin_time;
   logic [TIME_W-1:0]    rsp_finish_time;
   logic [TIME_W-1:0]    rsp_wait_ticks;
   logic [TIME_W-1:0]    rsp_server_busy_sum;

   // bench copy of the server table
   logic [TIME_W-1:0] server_free_at [SERVER_COUNT];
   logic [TIME_W-1:0] server_load [SERVER_COUNT];

   dispatch_rec_type expected_dispatches [$];
   int unsigned   jobs_sent = 0;     // beats accepted on req
   int unsigned   results_seen = 0;  // beats taken on rsp
   int unsigned   mismatch_count = 0;
   int unsigned   cycle_count = 0;
   logic [TIME_W-1:0] traffic_clock = 32'd200;  // running arrival tick of the random traffic

   logic gaps_on = 1'b1;   // random idle cycles on both sides
   int   hold_seq = 0;     // bump to request one long rsp hold-off

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   multi_server_job_dispatcher_unit #(
      .SERVER_COUNT(SERVER_COUNT)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_job_id          (req_job_id),
      .req_arrival_time    (req_arrival_time),
      .req_service_time    (req_service_time),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_job_tag         (rsp_job_tag),
      .rsp_server_number   (rsp_server_number),
      .rsp_begin_time      (rsp_begin_time),
      .rsp_finish_time     (rsp_finish_time),
      .rsp_wait_ticks      (rsp_wait_ticks),
      .rsp_server_busy_sum (rsp_server_busy_sum)
   );

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // 32-bit add that pins at the top of the range
   function automatic logic [TIME_W-1:0] clip_add(input logic [TIME_W-1:0] a,
                                                   input logic [SVC_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + (TIME_W + 1)'(b);
      return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
   endfunction

   // Assign one job and update the bench server table.
   // Scan from the top server down for one free at arrival; if none, the job
   // starts at the earliest release tick, ties going to the higher server.
   function automatic dispatch_rec_type predict_dispatch(input logic [TAG_W-1:0] id,
                                                         input logic [TIME_W-1:0] arrival,
                                                         input logic [SVC_W-1:0] service);
      dispatch_rec_type d;
      int pick;
      int k;
      logic [TIME_W-1:0] start;
      pick = -1;
      for (k = SERVER_COUNT - 1; k >= 0; k--)
         if (pick < 0 && server_free_at[k] <= arrival) pick = k;
      if (pick >= 0) begin
         start = arrival;
      end else begin
         // all busy: strict less-than keeps the higher number on a tie
         pick = SERVER_COUNT - 1;
         for (k = SERVER_COUNT - 2; k >= 0; k--)
            if (server_free_at[k] < server_free_at[pick]) pick = k;
         start = server_free_at[pick];
      end
      server_free_at[pick] = clip_add(start, service);
      server_load[pick]    = clip_add(server_load[pick], service);
      d.tag        = id;
      d.server     = SRV_NUM_W'(pick + 1);
      d.start_tick = start;
      d.end_tick   = server_free_at[pick];
      d.wait_ticks = start - arrival;
      d.busy_total = server_load[pick];
      return d;
   endfunction

   // Offer one job; returns at the edge that accepts it. Valid stays up after
   // acceptance so that a following job can go out with no bubble.
   task automatic send_job(input logic [TAG_W-1:0] id, input logic [TIME_W-1:0] arrival,
                           input logic [SVC_W-1:0] service);
      while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_job_id       <= id;
      req_arrival_time <= arrival;
      req_service_time <= service;
      do @(posedge clock); while (!req_ready);
      expected_dispatches.push_back(predict_dispatch(id, arrival, service));
      jobs_sent++;
   endtask

   // Drop valid and hold off until every accepted job has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_seen < jobs_sent);
   endtask

   // Tight arrivals with mid-size service times: mostly the all-busy path.
   task automatic send_burst(input int count);
      int n;
      for (n = 0; n < count; n++) begin
         traffic_clock += $urandom_range(0, 10);
         send_job(TAG_W'($urandom_range(0, 65535)), traffic_clock,
                  SVC_W'($urandom_range(50, 500)));
      end
   endtask

   // Receiver: random ready, plus one long hold-off per hold_seq bump.
   initial begin
      int hold_seen;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= !reset && !(gaps_on && $urandom_range(99) < IDLE_PCT);
      end
   end

   task automatic report_mismatch(input string why, input dispatch_rec_type want,
                                  input dispatch_rec_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("dispatch mismatch (%s) at cycle %0d", why, cycle_count);
         $display("  expected tag %h srv %0d start %h end %h wait %h total %h",
                  want.tag, want.server, want.start_tick, want.end_tick,
                  want.wait_ticks, want.busy_total);
         $display("  actual   tag %h srv %0d start %h end %h wait %h total %h",
                  got.tag, got.server, got.start_tick, got.end_tick,
                  got.wait_ticks, got.busy_total);
      end
   endtask

   // Result checker: every rsp beat against the oldest prediction.
   always @(posedge clock) begin : result_check
      dispatch_rec_type want;
      dispatch_rec_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.tag        = rsp_job_tag;
         got.server     = rsp_server_number;
         got.start_tick = rsp_begin_time;
         got.end_tick   = rsp_finish_time;
         got.wait_ticks = rsp_wait_ticks;
         got.busy_total = rsp_server_busy_sum;
         results_seen <= results_seen + 1;
         if (expected_dispatches.size() == 0) begin
            report_mismatch("beat with no job outstanding", '0, got);
         end else begin
            want = expected_dispatches.pop_front();
            if (got.tag != want.tag || got.server != want.server ||
                got.start_tick != want.start_tick || got.end_tick != want.end_tick ||
                got.wait_ticks != want.wait_ticks || got.busy_total != want.busy_total)
               report_mismatch("field differs", want, got);
         end
      end
   end

   // Small hand-built schedule: zero service, all servers busy with a tie,
   // a zero-length job landing on a just-freed server, then a free server again.
   task automatic test_directed_cases();
      int n;
      send_job(16'h0000, 32'd0, 16'd0);
      // fill every server until tick 41
      for (n = 1; n <= SERVER_COUNT; n++)
         send_job(TAG_W'(n), 32'd1, 16'd40);
      send_job(16'd7, 32'd2, 16'd7);     // all busy, six-way tie at 41
      send_job(16'd8, 32'd41, 16'd0);    // server freed exactly at arrival
      send_job(16'd9, 32'd3, 16'd5);     // all busy, tie among the lower five
      send_job(16'd10, 32'd100, 16'h8000);
   endtask

   // Bulk traffic: bursts that overload all six servers, broken by long quiet
   // gaps that let them drain. A few jobs arrive late (tick behind earlier
   // jobs). One stretch runs with no idle cycles on either side.
   task automatic test_random_traffic(input int unsigned jobs);
      int unsigned n;
      int unsigned roll;
      logic [TIME_W-1:0] arrival;
      logic [SVC_W-1:0]  service;
      for (n = 0; n < jobs; n++) begin
         if (n == jobs / 3) gaps_on <= 1'b0;
         if (n == jobs / 3 + 300) gaps_on <= 1'b1;
         roll = $urandom_range(99);
         if (roll < 85) traffic_clock += $urandom_range(0, 40);
         else if (roll < 97) traffic_clock += $urandom_range(41, 400);
         else traffic_clock += $urandom_range(401, 70000);
         arrival = traffic_clock;
         if ($urandom_range(99) < 4)
            arrival = traffic_clock -
                      $urandom_range(0, traffic_clock < 3000 ? traffic_clock : 3000);
         roll = $urandom_range(99);
         if (roll < 3) service = '0;
         else if (roll < 5) service = SVC_W'($urandom_range(0, 65535));
         else service = SVC_W'($urandom_range(1, 600));
         send_job(TAG_W'($urandom_range(0, 65535)), arrival, service);
      end
   endtask

   // rsp side stops taking beats for a long stretch while jobs keep coming;
   // the single-entry block backs up and drops req_ready.
   task automatic test_output_stall();
      hold_seq <= hold_seq + 1;
      send_burst(25);
   endtask

   // sender goes quiet until every result is back, then resumes
   task automatic test_paused_sender();
      send_burst(20);
      wait_drained();
      send_burst(20);
   endtask

   // Top of the tick range: finish and stored busy-until pin at all ones.
   // Run last, since a server pinned there stays busy for any later tick.
   task automatic test_end_of_time();
      int n;
      send_job(16'h5555, 32'h5555_5555, 16'h5555);
      send_job(16'hAAAA, 32'hAAAA_AAAA, 16'hAAAA);
      send_job(16'hFFFF, 32'hFFFF_FFF0, 16'hFFFF);
      send_job(16'h0001, TIME_MAX, 16'h0000);
      send_job(16'h1234, TIME_MAX, 16'hFFFF);
      for (n = 0; n < 40; n++)
         send_job(TAG_W'($urandom_range(0, 65535)),
                  $urandom_range(32'hFFFF_0000, 32'hFFFF_FFFF),
                  SVC_W'($urandom_range(0, 65535)));
   endtask

   initial begin
      int k;
      for (k = 0; k < SERVER_COUNT; k++) begin
         server_free_at[k] = '0;
         server_load[k]    = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_traffic(1700);
      test_output_stall();
      test_paused_sender();
      test_end_of_time();

      // all results in, then wait on to catch stray beats
      wait_drained();
      repeat (2 * SERVER_COUNT + 8) @(posedge clock);
      if (mismatch_count == 0 && expected_dispatches.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire
